/* rtl/core/playfair_digraph_cipher_defines.svh */
// Assertion macros shared by the Playfair cipher checker.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfc check failed");

// next-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfc check failed");

`endif

/* rtl/core/pfc_pkg.sv */
// Shared types, constants and helper functions of the Playfair cipher.
package pfc_pkg;

	localparam logic [4:0] LET_I    = 5'd8;
	localparam logic [4:0] LET_J    = 5'd9;
	localparam logic [4:0] LET_X    = 5'd23;
	localparam logic [4:0] SQ_CELLS = 5'd25;
	localparam logic [4:0] LAST_LET = 5'd25;
	localparam logic [6:0] ASCII_A  = 7'd65;
	localparam int         SQ_DEPTH  = 25;
	localparam int         POS_DEPTH = 26;

	typedef enum logic [2:0] {
		OP_CLEAR    = 3'd0,
		OP_KEY      = 3'd1,
		OP_KEY_END  = 3'd2,
		OP_TEXT     = 3'd3,
		OP_TEXT_END = 3'd4
	} pfc_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOK,
		ST_CELL,
		ST_EMIT
	} pfc_state_t;

	typedef struct packed {
		logic accept;
		logic walk;
		logic emit;
	} pfc_cmd_t;

	typedef struct packed {
		logic starts_fill;
		logic makes_pair;
		logic walk_last;
		logic out_free;
	} pfc_stat_t;

	function automatic logic is_letter(input logic [7:0] ch);
		return ((ch >= 8'd97) && (ch <= 8'd122)) || ((ch >= 8'd65) && (ch <= 8'd90));
	endfunction

	function automatic logic [4:0] letter_idx(input logic [7:0] ch);
		logic [7:0] t;
		t = (ch >= 8'd97) ? (ch - 8'd97) : (ch - 8'd65);
		return t[4:0];
	endfunction

	function automatic logic [2:0] pos_row(input logic [4:0] p);
		logic [2:0] r;
		if (p >= 5'd20)
			r = 3'd4;
		else if (p >= 5'd15)
			r = 3'd3;
		else if (p >= 5'd10)
			r = 3'd2;
		else if (p >= 5'd5)
			r = 3'd1;
		else
			r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] pos_col(input logic [4:0] p);
		logic [4:0] base;
		logic [4:0] c;
		base = ({2'b00, pos_row(p)} << 2) + {2'b00, pos_row(p)};
		c = p - base;
		return c[2:0];
	endfunction

	function automatic logic [2:0] step5(input logic [2:0] x, input logic enc);
		logic [2:0] y;
		if (enc)
			y = (x == 3'd4) ? 3'd0 : x + 3'd1;
		else
			y = (x == 3'd0) ? 3'd4 : x - 3'd1;
		return y;
	endfunction

	function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

/* rtl/core/pfc_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

/* rtl/core/pfc_dp.sv */
// Datapath: key square tables, text pairing, pair transform and output register.
module pfc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pfc_pkg::pfc_cmd_t cmd,
	output pfc_pkg::pfc_stat_t stat,
	input  logic [2:0]        s_axis_tuser,
	input  logic [7:0]        s_axis_tdata,
	input  logic              m_axis_tready,
	output logic              m_axis_tvalid,
	output logic [15:0]       m_axis_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	pfc_pkg::pfc_op_t op;
	logic        in_letter;
	logic [4:0]  in_idx;
	logic [4:0]  text_idx;
	logic [25:0] used_q;
	logic [4:0]  fill_q;
	logic        pend_valid_q;
	logic [4:0]  pend_letter_q;
	logic [4:0]  walk_q;
	logic        enc_q;
	logic [4:0]  a_q;
	logic [4:0]  b_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        place_req;
	logic [4:0]  place_l;
	logic        place_en;
	logic [4:0]  pos_a;
	logic [4:0]  pos_b;
	logic [4:0]  sq_a;
	logic [4:0]  sq_b;
	logic [4:0]  sq_addr_a;
	logic [4:0]  sq_addr_b;
	logic [2:0]  ra, ca, rb, cb;

	assign op        = pfc_pkg::pfc_op_t'(s_axis_tuser);
	assign in_letter = pfc_pkg::is_letter(s_axis_tdata);
	assign in_idx    = pfc_pkg::letter_idx(s_axis_tdata);
	assign text_idx  = (in_idx == pfc_pkg::LET_J) ? pfc_pkg::LET_I : in_idx;
	assign cfg_ready = 1'b1;

	assign stat.starts_fill = (op == pfc_pkg::OP_KEY_END);
	assign stat.makes_pair  = pend_valid_q &&
		(((op == pfc_pkg::OP_TEXT) && in_letter) || (op == pfc_pkg::OP_TEXT_END));
	assign stat.walk_last   = (walk_q == pfc_pkg::LAST_LET);
	assign stat.out_free    = !out_valid_q || m_axis_tready;

	always_comb begin
		place_req = 1'b0;
		place_l   = walk_q;
		if (cmd.accept && (op == pfc_pkg::OP_KEY) && in_letter && (in_idx != pfc_pkg::LET_J)) begin
			place_req = 1'b1;
			place_l   = in_idx;
		end
		if (cmd.walk && (walk_q != pfc_pkg::LET_J)) begin
			place_req = 1'b1;
			place_l   = walk_q;
		end
	end

	assign place_en = place_req && (fill_q < pfc_pkg::SQ_CELLS) && !used_q[place_l];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			fill_q        <= '0;
			pend_valid_q  <= 1'b0;
			pend_letter_q <= '0;
			walk_q        <= '0;
			enc_q         <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				enc_q <= cfg_data;
			if (place_en) begin
				used_q[place_l] <= 1'b1;
				fill_q          <= fill_q + 5'd1;
			end
			if (cmd.walk)
				walk_q <= walk_q + 5'd1;
			if (cmd.accept) begin
				case (op)
					pfc_pkg::OP_CLEAR: begin
						used_q        <= '0;
						fill_q        <= '0;
						pend_valid_q  <= 1'b0;
						pend_letter_q <= '0;
					end
					pfc_pkg::OP_KEY_END: begin
						walk_q <= '0;
					end
					pfc_pkg::OP_TEXT: begin
						if (in_letter) begin
							if (!pend_valid_q) begin
								pend_valid_q  <= 1'b1;
								pend_letter_q <= text_idx;
							end else if (!(enc_q && (pend_letter_q == text_idx))) begin
								pend_valid_q  <= 1'b0;
								pend_letter_q <= '0;
							end
						end
					end
					pfc_pkg::OP_TEXT_END: begin
						pend_valid_q  <= 1'b0;
						pend_letter_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// latch the pair; a doubled letter while encrypting, or text end, pairs with X
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q <= pend_letter_q;
			if ((op == pfc_pkg::OP_TEXT_END) || (enc_q && (pend_letter_q == text_idx)))
				b_q <= pfc_pkg::LET_X;
			else
				b_q <= text_idx;
		end
		if (cmd.emit)
			out_data_q <= {2'b00, pfc_pkg::ASCII_A + {2'b00, sq_b},
				pfc_pkg::ASCII_A + {2'b00, sq_a}};
	end

	pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::POS_DEPTH)) u_pos_ram (
		.clk    (clk),
		.we     (place_en),
		.waddr  (place_l),
		.wdata  (fill_q),
		.raddr0 (a_q),
		.raddr1 (b_q),
		.rdata0 (pos_a),
		.rdata1 (pos_b)
	);

	assign ra = pfc_pkg::pos_row(pos_a);
	assign ca = pfc_pkg::pos_col(pos_a);
	assign rb = pfc_pkg::pos_row(pos_b);
	assign cb = pfc_pkg::pos_col(pos_b);

	always_comb begin
		if (ca == cb) begin
			sq_addr_a = pfc_pkg::cell_addr(pfc_pkg::step5(ra, enc_q), ca);
			sq_addr_b = pfc_pkg::cell_addr(pfc_pkg::step5(rb, enc_q), cb);
		end else if (ra == rb) begin
			sq_addr_a = pfc_pkg::cell_addr(ra, pfc_pkg::step5(ca, enc_q));
			sq_addr_b = pfc_pkg::cell_addr(rb, pfc_pkg::step5(cb, enc_q));
		end else begin
			sq_addr_a = pfc_pkg::cell_addr(ra, cb);
			sq_addr_b = pfc_pkg::cell_addr(rb, ca);
		end
	end

	pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::SQ_DEPTH)) u_sq_ram (
		.clk    (clk),
		.we     (place_en),
		.waddr  (fill_q),
		.wdata  (place_l),
		.raddr0 (sq_addr_a),
		.raddr1 (sq_addr_b),
		.rdata0 (sq_a),
		.rdata1 (sq_b)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/core/pfc_ctrl.sv */
// Controller state machine: item intake, key fill walk and pair lookup sequence.
module pfc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  pfc_pkg::pfc_stat_t stat,
	output pfc_pkg::pfc_cmd_t  cmd
);

	pfc_pkg::pfc_state_t state_q;
	pfc_pkg::pfc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pfc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			pfc_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.accept = 1'b1;
					if (stat.starts_fill)
						state_d = pfc_pkg::ST_FILL;
					else if (stat.makes_pair)
						state_d = pfc_pkg::ST_LOOK;
				end
			end
			pfc_pkg::ST_FILL: begin
				cmd.walk = 1'b1;
				if (stat.walk_last)
					state_d = pfc_pkg::ST_IDLE;
			end
			pfc_pkg::ST_LOOK: begin
				state_d = pfc_pkg::ST_CELL;
			end
			pfc_pkg::ST_CELL: begin
				state_d = pfc_pkg::ST_EMIT;
			end
			pfc_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = pfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/playfair_digraph_cipher.sv */
// Top level of the Playfair digraph cipher engine.
// Input stream: tuser carries the opcode (clear key, key character, key end,
// text character, text end), tdata carries the raw character byte.
// Output stream: one item per completed letter pair, two ASCII capitals.
// cfg_data sets the mode (1 encrypt, 0 decrypt); write it only while idle.
// Clear key, key character and text characters that complete no pair keep
// the controller idle: tready stays high.
// Key end walks the alphabet one letter per cycle.
// A completed pair goes through accept, position lookup in the letter
// table, square lookup, then the result is loaded into the output register
// once it is free. The two table reads of each lookup use the two read
// ports of one dual-read RAM in the same cycle.
// The output register holds a result while the receiver stalls; the next
// items are still taken until another result must be loaded.
// Reset clears the key, the pending text letter and the output valid flag, and
// selects encrypt mode; the key tables hold garbage until a key is loaded.
module playfair_digraph_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,  // [2:0] opcode
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [6:0] first_char, [13:7] second_char, [15:14] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	pfc_pkg::pfc_cmd_t  cmd;
	pfc_pkg::pfc_stat_t stat;

	pfc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	pfc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

endmodule

/* rtl/core/pfc_checker.sv */
// Port-level checker of the Playfair cipher, bound to the top level.
`include "playfair_digraph_cipher_defines.svh"

module pfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic key_end_in;
	logic out_stall;
	logic first_ok;
	logic second_ok;
	logic out_letters_ok;

	assign key_end_in = s_axis_tvalid && s_axis_tready &&
		(s_axis_tuser == pfc_pkg::OP_KEY_END);
	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign first_ok   = (m_axis_tdata[6:0] >= 7'd65) && (m_axis_tdata[6:0] <= 7'd90);
	assign second_ok  = (m_axis_tdata[13:7] >= 7'd65) && (m_axis_tdata[13:7] <= 7'd90);
	assign out_letters_ok = first_ok && second_ok && (m_axis_tdata[15:14] == 2'b00);

	`PFC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
	`PFC_ASSERT_NOW(a_out_letters, m_axis_tvalid, out_letters_ok)
	`PFC_ASSERT_NEXT(a_fill_busy, key_end_in, !s_axis_tready)
	`PFC_ASSERT_NOW(a_emit_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/playfair_digraph_cipher_tb.sv */
// Self-checking testbench for the Playfair digraph cipher engine.
module playfair_digraph_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_NOP_LO = 3'd5;
	localparam logic [2:0] OP_NOP_HI = 3'd7;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 185;
	localparam int PHASES        = 8;
	localparam int SIDE          = 5;

	typedef struct packed {
		logic [6:0] first_char;
		logic [6:0] second_char;
	} letter_pair_t;

	class playfair_scoreboard;
		logic [4:0]   square [pfc_pkg::SQ_DEPTH];
		logic [4:0]   where [pfc_pkg::POS_DEPTH];
		logic [25:0]  placed;
		int           filled;
		bit           pend_v;
		logic [4:0]   pend_l;
		bit           enc;
		letter_pair_t expected_pairs [$];
		int           errors;

		function new();
			placed = '0;
			filled = 0;
			pend_v = 1'b0;
			pend_l = '0;
			enc = 1'b1;
			errors = 0;
		endfunction

		function int letter_index(logic [7:0] ch);
			if (ch >= "a" && ch <= "z")
				return ch - "a";
			if (ch >= "A" && ch <= "Z")
				return ch - "A";
			return -1;
		endfunction

		function void place(logic [4:0] l);
			if (filled >= pfc_pkg::SQ_DEPTH || placed[l])
				return;
			square[filled] = l;
			where[l] = 5'(filled);
			placed[l] = 1'b1;
			filled++;
		endfunction

		function logic [6:0] letter_at(int r, int c);
			return 7'(pfc_pkg::ASCII_A + square[(r % SIDE) * SIDE + c % SIDE]);
		endfunction

		function void push_pair(logic [4:0] a, logic [4:0] b);
			int pa, pb, ra, ca, rb, cb, d;
			letter_pair_t e;
			pa = int'(where[a]);
			pb = int'(where[b]);
			ra = pa / SIDE;
			ca = pa % SIDE;
			rb = pb / SIDE;
			cb = pb % SIDE;
			d = enc ? 1 : SIDE - 1;
			if (ca == cb) begin
				e.first_char = letter_at(ra + d, ca);
				e.second_char = letter_at(rb + d, cb);
			end else if (ra == rb) begin
				e.first_char = letter_at(ra, ca + d);
				e.second_char = letter_at(rb, cb + d);
			end else begin
				e.first_char = letter_at(ra, cb);
				e.second_char = letter_at(rb, ca);
			end
			expected_pairs.insert(expected_pairs.size(), e);
		endfunction

		function void note_item(logic [2:0] op, logic [7:0] ch);
			int l;
			case (op)
				pfc_pkg::OP_CLEAR: begin
					placed = '0;
					filled = 0;
					pend_v = 1'b0;
					pend_l = '0;
				end
				pfc_pkg::OP_KEY: begin
					l = letter_index(ch);
					if (l >= 0 && l != pfc_pkg::LET_J)
						place(5'(l));
				end
				pfc_pkg::OP_KEY_END: begin
					for (l = 0; l < pfc_pkg::POS_DEPTH; l++)
						if (l != pfc_pkg::LET_J)
							place(5'(l));
				end
				pfc_pkg::OP_TEXT: begin
					l = letter_index(ch);
					if (l >= 0) begin
						if (l == pfc_pkg::LET_J)
							l = pfc_pkg::LET_I;
						if (!pend_v) begin
							pend_v = 1'b1;
							pend_l = 5'(l);
						end else if (enc && pend_l == 5'(l)) begin
							push_pair(pend_l, pfc_pkg::LET_X);
						end else begin
							push_pair(pend_l, 5'(l));
							pend_v = 1'b0;
							pend_l = '0;
						end
					end
				end
				pfc_pkg::OP_TEXT_END: begin
					if (pend_v) begin
						push_pair(pend_l, pfc_pkg::LET_X);
						pend_v = 1'b0;
						pend_l = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_pair(logic [15:0] data);
			letter_pair_t e;
			if (expected_pairs.size() == 0) begin
				$error("unexpected pair item %h", data);
				errors++;
				return;
			end
			e = expected_pairs.pop_front();
			if (data[6:0] !== e.first_char) begin
				$error("first_char expected %0d actual %0d", e.first_char, data[6:0]);
				errors++;
			end
			if (data[13:7] !== e.second_char) begin
				$error("second_char expected %0d actual %0d", e.second_char, data[13:7]);
				errors++;
			end
			if (data[15:14] !== 2'b00) begin
				$error("pad expected 0 actual %0d", data[15:14]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [2:0]  s_axis_tuser = pfc_pkg::OP_CLEAR;  // [2:0] opcode
	logic [7:0]  s_axis_tdata = 8'd0;      // [7:0] ch
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;             // [6:0] first_char, [13:7] second_char, [15:14] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	playfair_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int items_sent;
	int hold_asks;
	int hold_seen;
	int hold_left;
	int cycle_count;

	playfair_digraph_cipher DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("playfair_digraph_cipher test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_pair(m_axis_tdata);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic logic [7:0] cased(input int idx);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + idx);
	endfunction

	function automatic logic [7:0] stray_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 64));
			1: return 8'($urandom_range(91, 96));
			default: return 8'($urandom_range(123, 255));
		endcase
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [7:0] ch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_item(op, ch);
		if (op <= pfc_pkg::OP_TEXT_END)
			items_sent++;
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pairs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.enc = mode;
	endtask

	task automatic send_key();
		int n, base;
		send_item(pfc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) begin
			// whole alphabet plus a few more: square fills, the rest is dropped
			base = $urandom_range(0, 25);
			for (int i = 0; i < 29; i++)
				send_item(pfc_pkg::OP_KEY, cased((base + i) % 26));
		end else begin
			n = $urandom_range(0, 12);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_item(pfc_pkg::OP_KEY, stray_byte());
				else
					send_item(pfc_pkg::OP_KEY, cased($urandom_range(0, 25)));
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_item(pfc_pkg::OP_KEY_END, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			send_item(pfc_pkg::OP_KEY_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_text();
		int n, r, idx;
		idx = $urandom_range(0, 25);
		n = $urandom_range(1, 24);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_item(pfc_pkg::OP_TEXT, stray_byte());
			end else begin
				if (r < 12)
					idx = pfc_pkg::LET_J;
				else if (r < 17)
					idx = pfc_pkg::LET_X;
				else if (r >= 37)
					idx = $urandom_range(0, 25);
				send_item(pfc_pkg::OP_TEXT, cased(idx));
			end
		end
		if ($urandom_range(0, 99) < 85)
			send_item(pfc_pkg::OP_TEXT_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic run_directed();
		send_item(pfc_pkg::OP_CLEAR, 8'hFF);
		send_item(pfc_pkg::OP_KEY, "p");
		send_item(pfc_pkg::OP_KEY, "L");
		send_item(pfc_pkg::OP_KEY, "a");
		send_item(pfc_pkg::OP_KEY, "y");
		send_item(pfc_pkg::OP_KEY, "j");
		send_item(pfc_pkg::OP_KEY, "!");
		send_item(pfc_pkg::OP_KEY, "r");
		send_item(pfc_pkg::OP_KEY_END, 8'h00);
		send_item(pfc_pkg::OP_KEY_END, 8'h5A);
		send_item(pfc_pkg::OP_TEXT, "h");
		send_item(pfc_pkg::OP_TEXT, "i");
		send_item(pfc_pkg::OP_TEXT, "e");
		send_item(pfc_pkg::OP_TEXT, "E");
		send_item(pfc_pkg::OP_TEXT, "J");
		send_item(pfc_pkg::OP_TEXT, "x");
		send_item(pfc_pkg::OP_TEXT, "X");
		send_item(pfc_pkg::OP_TEXT, 8'h7B);
		send_item(pfc_pkg::OP_TEXT, 8'h40);
		send_item(OP_NOP_LO, 8'hAA);
		send_item(3'd6, 8'h55);
		send_item(OP_NOP_HI, 8'hAA);
		send_item(pfc_pkg::OP_TEXT_END, 8'h80);
		send_item(pfc_pkg::OP_TEXT_END, 8'h7F);
		send_item(pfc_pkg::OP_TEXT, "z");
	endtask

	task automatic run_random(input int target);
		int goal, r;
		goal = items_sent + target;
		while (items_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				wait_drain();
			if (r < 85) begin
				if (r < 30)
					send_key();
				repeat ($urandom_range(1, 3)) send_text();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1))
						send_item(3'($urandom_range(OP_NOP_LO, OP_NOP_HI)),
							8'($urandom_range(0, 255)));
					else
						send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	task automatic hold_off_burst();
		hold_asks <= hold_asks + 1;
		repeat (80) send_item(pfc_pkg::OP_TEXT, cased($urandom_range(0, 25)));
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 51;
				end
				default: begin
					send_idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			write_mode(p % 2 == 0);
			if (p == 0)
				run_directed();
			if (p == 1)
				hold_off_burst();
			run_random(PHASE_ITEMS);
		end
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_pairs.size() == 0)
			$display("playfair_digraph_cipher test passed");
		else
			$display("playfair_digraph_cipher test failed");
		$finish;
	end

endmodule
